FILE: rtl/core/mie_pkg.sv
package mie_pkg;

   // Field widths of the request and response beats.
   localparam int WIDTH = 32;
   localparam int VW    = WIDTH + 1;

   // Cofactor width. The arithmetic wraps at this width, and the true values stay well inside it.
   localparam int CW    = WIDTH + 3;

   // Width of the divider's alignment counter. It must hold up to VW - 1.
   localparam int CNTW  = $clog2(VW);

   // Response status codes.
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_NOT_INVERT  = 2'd1;
   localparam logic [1:0] ST_BAD_MODULUS = 2'd2;

   typedef struct packed {
      logic signed [VW-1:0] value;
      logic [WIDTH-1:0]     modulus;
   } req_type;

   typedef struct packed {
      logic [WIDTH-1:0] inverse;
      logic [WIDTH-1:0] divisor;
      logic [1:0]       status;
   } rsp_type;

   // Command to the shared divider. It also accumulates quotient * mult.
   typedef struct packed {
      logic             start;
      logic [VW-1:0]    dividend;
      logic [WIDTH-1:0] divisor;
      logic [CW-1:0]    mult;
   } div_cmd_type;

   typedef struct packed {
      logic             done;
      logic [WIDTH-1:0] remainder;
      logic [CW-1:0]    product;
   } div_rsp_type;

endpackage

FILE: rtl/core/mie_divider.sv
module mie_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  mie_pkg::div_cmd_type cmd,
   output mie_pkg::div_rsp_type rsp
);
   import mie_pkg::*;

   typedef enum logic [1:0] {PH_IDLE, PH_ALIGN, PH_SUB} phase_type;

   phase_type       phase_ff, phase_in;
   logic [VW-1:0]   rem_ff, rem_in;
   logic [VW-1:0]   div_ff, div_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0]   prod_ff, prod_in;
   logic [CW-1:0]   mult_ff, mult_in;
   logic            done_ff, done_in;
   logic [VW:0]     div_dbl;
   logic            fits;

   // The unit first shifts the divisor up under the dividend.
   // It then does one restoring subtract per cycle, MSB first.
   // Each quotient bit also folds mult into the running product.
   always_comb begin
      div_dbl  = {div_ff, 1'b0};
      fits     = (rem_ff >= div_ff);
      phase_in = phase_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      mult_in  = mult_ff;
      done_in  = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (cmd.start) begin
               rem_in   = cmd.dividend;
               div_in   = {1'b0, cmd.divisor};
               mult_in  = cmd.mult;
               prod_in  = '0;
               cnt_in   = '0;
               phase_in = PH_ALIGN;
            end
         end
         PH_ALIGN: begin
            if (div_dbl <= {1'b0, rem_ff}) begin
               div_in = div_dbl[VW-1:0];
               cnt_in = cnt_ff + 1'b1;
            end else begin
               phase_in = PH_SUB;
            end
         end
         PH_SUB: begin
            if (fits) begin
               rem_in = rem_ff - div_ff;
            end
            prod_in = {prod_ff[CW-2:0], 1'b0} + ({CW{fits}} & mult_ff);
            if (cnt_ff == '0) begin
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end else begin
               div_in = div_ff >> 1;
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Hold the state and the registered results.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
      mult_ff <= mult_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff[WIDTH-1:0];
   assign rsp.product   = prod_ff;

`ifndef NO_ASSERTIONS
   // Restoring division needs the remainder below twice the current divisor.
   a_sub_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SUB) |-> ({1'b0, rem_ff} < div_dbl))
      else $error("divider remainder out of range during subtract");

   // The final remainder lies below the unshifted divisor.
   a_done_rem: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < div_ff))
      else $error("divider finished with remainder not below divisor");

   // The alignment shift never passes the dividend width.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (cnt_ff < CNTW'(VW)))
      else $error("divider alignment count overflow");
`endif

endmodule

FILE: rtl/core/modular_inverse_extended_euclid.sv
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   mie_pkg::req_type (value, modulus)
// rsp_      out        rsp_valid/rsp_stall   mie_pkg::rsp_type (inverse, divisor, status)
//
// One shift-subtract divider is shared by the first reduction and every Euclid round.
// Consecutive Fibonacci operands take the most rounds; a modulus below two skips the divider.
// The block takes one item at a time. req_stall is high from acceptance until the result
// is loaded into the output register. It can accept the next item while that result waits.
// Reset is synchronous and clears the sequencer, the divider and the output valid.
module modular_inverse_extended_euclid (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mie_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mie_pkg::rsp_type rsp_data
);
   import mie_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_REDUCE, S_LOOP, S_DIVIDE, S_FINISH} state_type;

   state_type        state_ff, state_in;
   logic [WIDTH-1:0] m_ff, m_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [CW-1:0]    c0_ff, c0_in;
   logic [CW-1:0]    c1_ff, c1_in;
   logic             neg_ff, neg_in;
   logic             bad_ff, bad_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   div_cmd_type      div_cmd;
   div_rsp_type      div_rsp;

   logic             accept;
   logic             out_free;
   logic [VW-1:0]    mag;
   logic [WIDTH-1:0] red_adj;
   logic [CW-1:0]    t_next;
   logic [CW-1:0]    m_ext;
   logic [CW-1:0]    c0_fix;
   logic [CW-1:0]    x_val;
   logic             c0_neg;
   logic             c0_high;

   mie_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   // Handshake and magnitude of the incoming value.
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign mag       = req_data.value[VW-1] ? (~req_data.value + 1'b1) : req_data.value;

   // Divider commands: the reduction at acceptance of a modulus of two or more, then one per Euclid round.
   always_comb begin
      div_cmd.start    = (accept && (req_data.modulus >= WIDTH'(2)))
                         || ((state_ff == S_LOOP) && (b_ff != '0));
      div_cmd.dividend = (state_ff == S_IDLE) ? mag : {1'b0, a_ff};
      div_cmd.divisor  = (state_ff == S_IDLE) ? req_data.modulus : b_ff;
      div_cmd.mult     = (state_ff == S_IDLE) ? '0 : c1_ff;
   end

   // Arithmetic around the divider: sign fix-up, cofactor update and final normalization.
   always_comb begin
      red_adj = (neg_ff && (div_rsp.remainder != '0)) ? (m_ff - div_rsp.remainder)
                                                      : div_rsp.remainder;
      t_next  = c0_ff - div_rsp.product;
      m_ext   = {{(CW-WIDTH){1'b0}}, m_ff};
      c0_neg  = c0_ff[CW-1];
      c0_high = !c0_neg && (c0_ff >= m_ext);
      c0_fix  = c0_neg ? (c0_ff + m_ext) : (c0_ff - m_ext);
      x_val   = (c0_neg || c0_high) ? c0_fix : c0_ff;
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      m_in         = m_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c0_in        = c0_ff;
      c1_in        = c1_ff;
      neg_in       = neg_ff;
      bad_in       = bad_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               m_in     = req_data.modulus;
               neg_in   = req_data.value[VW-1];
               bad_in   = (req_data.modulus < WIDTH'(2));
               state_in = (req_data.modulus < WIDTH'(2)) ? S_FINISH : S_REDUCE;
            end
         end
         S_REDUCE: begin
            if (div_rsp.done) begin
               a_in     = red_adj;
               b_in     = m_ff;
               c0_in    = CW'(1);
               c1_in    = '0;
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            state_in = (b_ff == '0) ? S_FINISH : S_DIVIDE;
         end
         S_DIVIDE: begin
            if (div_rsp.done) begin
               c0_in    = c1_ff;
               c1_in    = t_next;
               a_in     = b_ff;
               b_in     = div_rsp.remainder;
               state_in = S_LOOP;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (bad_ff) begin
                  rsp_data_in.inverse = '0;
                  rsp_data_in.divisor = '0;
                  rsp_data_in.status  = ST_BAD_MODULUS;
               end else if (a_ff != WIDTH'(1)) begin
                  rsp_data_in.inverse = '0;
                  rsp_data_in.divisor = a_ff;
                  rsp_data_in.status  = ST_NOT_INVERT;
               end else begin
                  rsp_data_in.inverse = x_val[WIDTH-1:0];
                  rsp_data_in.divisor = WIDTH'(1);
                  rsp_data_in.status  = ST_OK;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      m_ff        <= m_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      c0_ff       <= c0_in;
      c1_ff       <= c1_in;
      neg_ff      <= neg_in;
      bad_ff      <= bad_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // The divider reports only while the sequencer waits for it.
   a_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> ((state_ff == S_REDUCE) || (state_ff == S_DIVIDE)))
      else $error("divider finished outside a waiting state");

   // A new response beat comes only out of the finish state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("response raised outside finish");

   // A Euclid round never divides by zero.
   a_nonzero_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVIDE) |-> (b_ff != '0))
      else $error("division by zero in Euclid round");
`endif

endmodule

FILE: tb/tb_modular_inverse_extended_euclid.sv
module tb_modular_inverse_extended_euclid;
   timeunit 1ns;
   timeprecision 1ps;

   import mie_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 3_000_000;
   localparam int          NUM_DIRECTED  = 22;
   localparam int          PHASE_ITEMS   = 476;
   localparam int          SETTLE_CYCLES = 16;

   // One directed beat: when pinned is set, the answer is checked as typed.
   typedef struct {
      logic signed [VW-1:0] value;
      logic [WIDTH-1:0]     modulus;
      bit                   pinned;
      rsp_type              answer;
   } directed_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type     inverses_due[$];
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned send_gap_pct = 0;
   int unsigned recv_stall_pct = 0;

   directed_row_type directed_rows [NUM_DIRECTED] = '{
      // Modulus below two, with extreme values.
      '{33'sd5,           32'd0,           1'b1, '{32'd0, 32'd0, ST_BAD_MODULUS}},
      '{-33'sd1,          32'd1,           1'b1, '{32'd0, 32'd0, ST_BAD_MODULUS}},
      '{33'sh1_0000_0000, 32'd0,           1'b1, '{32'd0, 32'd0, ST_BAD_MODULUS}},
      '{33'sd12345,       32'd1,           1'b1, '{32'd0, 32'd0, ST_BAD_MODULUS}},
      '{33'sd0,           32'd0,           1'b1, '{32'd0, 32'd0, ST_BAD_MODULUS}},
      // Values that reduce to zero give the modulus as the gcd.
      '{33'sd0,           32'd7,           1'b1, '{32'd0, 32'd7, ST_NOT_INVERT}},
      '{33'sh0_FFFF_FFFF, 32'hFFFF_FFFF,   1'b1, '{32'd0, 32'hFFFF_FFFF, ST_NOT_INVERT}},
      '{33'sd4294967294,  32'd2,           1'b1, '{32'd0, 32'd2, ST_NOT_INVERT}},
      '{33'sh1_0000_0000, 32'd2,           1'b1, '{32'd0, 32'd2, ST_NOT_INVERT}},
      // A gcd other than one.
      '{33'sd6,           32'd9,           1'b1, '{32'd0, 32'd3, ST_NOT_INVERT}},
      // Trivial inverses.
      '{33'sd1,           32'd2,           1'b1, '{32'd1, 32'd1, ST_OK}},
      '{33'sd1,           32'hFFFF_FFFF,   1'b1, '{32'd1, 32'd1, ST_OK}},
      '{-33'sd1,          32'hFFFF_FFFF,   1'b1, '{32'hFFFF_FFFE, 32'd1, ST_OK}},
      '{33'sh0_FFFF_FFFF, 32'hFFFF_FFFE,   1'b1, '{32'd1, 32'd1, ST_OK}},
      // Everything below goes through the predictor.
      '{33'sd3,           32'd7,           1'b0, '0},
      '{-33'sd3,          32'd7,           1'b0, '0},
      '{33'sh1_0000_0000, 32'hFFFF_FFFF,   1'b0, '0},
      '{33'sd2,           32'hFFFF_FFFF,   1'b0, '0},
      '{33'sh0_FFFF_FFFF, 32'hFFFF_FFFD,   1'b0, '0},
      // Consecutive Fibonacci numbers take the most rounds; the last row reduces to zero.
      '{33'sd1836311903,  32'd2971215073,  1'b0, '0},
      '{-33'sd1836311903, 32'd2971215073,  1'b0, '0},
      '{33'sh0_AAAA_AAAA, 32'h5555_5555,   1'b0, '0}
   };

   modular_inverse_extended_euclid dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Reduce a two's complement 64-bit pattern into [0, m).
   function automatic logic [63:0] residue_of(logic [63:0] x, logic [63:0] m);
      logic [63:0] r;
      if (x[63]) begin
         r = (-x) % m;
         return (r != 64'd0) ? m - r : 64'd0;
      end
      return x % m;
   endfunction

   // Extended Euclid on the reduced value and the modulus, keeping the first cofactor only.
   function automatic rsp_type compute_inverse(req_type rq);
      logic [63:0] v, m, a, b, c0, c1, q, r, t;
      rsp_type     res;
      res = '0;
      v = {{(64 - VW){rq.value[VW-1]}}, rq.value};
      m = 64'(rq.modulus);
      if (m < 64'd2) begin
         res.status = ST_BAD_MODULUS;
         return res;
      end
      a  = residue_of(v, m);
      b  = m;
      c0 = 64'd1;
      c1 = 64'd0;
      while (b != 64'd0) begin
         q  = a / b;
         r  = a % b;
         t  = c0 - q * c1;
         c0 = c1;
         c1 = t;
         a  = b;
         b  = r;
      end
      res.divisor = a[WIDTH-1:0];
      if (a != 64'd1) begin
         res.status = ST_NOT_INVERT;
      end else begin
         res.inverse = WIDTH'(residue_of(c0, m));
         res.status  = ST_OK;
      end
      return res;
   endfunction

   // Random request beat, weighted toward edge moduli and special values.
   function automatic req_type random_request();
      req_type     rq;
      int unsigned pick;
      int          near_zero;
      pick = $urandom_range(99);
      if (pick < 5) begin
         rq.modulus = WIDTH'($urandom_range(1, 0));
      end else if (pick < 20) begin
         rq.modulus = WIDTH'($urandom_range(255, 2));
      end else if (pick < 30) begin
         rq.modulus = 32'hFFFF_FFFF - WIDTH'($urandom_range(15, 0));
      end else begin
         rq.modulus = $urandom;
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
         near_zero = int'($urandom_range(512, 0)) - 256;
         rq.value  = VW'(near_zero);
      end else if (pick < 15) begin
         case ($urandom_range(3, 0))
            0:       rq.value = 33'sh1_0000_0000;
            1:       rq.value = 33'sh0_FFFF_FFFF;
            2:       rq.value = 33'sd0;
            default: rq.value = -33'sd1;
         endcase
      end else if (pick < 20) begin
         // A plus or minus multiple of the modulus reduces to zero.
         rq.value = $urandom_range(1, 0) ? VW'(longint'(rq.modulus))
                                         : VW'(-longint'(rq.modulus));
      end else begin
         rq.value = {1'($urandom), 32'($urandom)};
      end
      return rq;
   endfunction

   // Drive one request beat, idling first on a share of the cycles, and record its answer.
   task automatic send_request(req_type rq, bit pinned, rsp_type answer);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (req_stall);
      inverses_due.push_back(pinned ? answer : compute_inverse(rq));
   endtask

   // Hold the request channel idle until every outstanding result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (inverses_due.size() != 0);
   endtask

   task automatic run_random_phase(int unsigned gap_pct, int unsigned stall_pct);
      send_gap_pct   = gap_pct;
      recv_stall_pct = stall_pct;
      repeat (PHASE_ITEMS) send_request(random_request(), 1'b0, '0);
      drain_results();
   endtask

   task automatic report_field(string field, logic [WIDTH-1:0] want, logic [WIDTH-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
         mismatches++;
      end
   endtask

   // Receiver back-pressure, redrawn every cycle.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Compare every accepted result beat with the oldest outstanding answer.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (inverses_due.size() == 0) begin
            $display("%0t: unexpected result beat, inverse %h divisor %h status %0d",
                     $time, rsp_data.inverse, rsp_data.divisor, rsp_data.status);
            mismatches++;
         end else begin
            want = inverses_due.pop_front();
            report_field("inverse", want.inverse, rsp_data.inverse);
            report_field("divisor", want.divisor, rsp_data.divisor);
            report_field("status", WIDTH'(want.status), WIDTH'(rsp_data.status));
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      req_type rq;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed beats first, with a full drain halfway through.
      send_gap_pct   = 24;
      recv_stall_pct = 48;
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         rq.value   = directed_rows[i].value;
         rq.modulus = directed_rows[i].modulus;
         send_request(rq, directed_rows[i].pinned, directed_rows[i].answer);
         if (i == NUM_DIRECTED / 2) begin
            drain_results();
         end
      end
      drain_results();

      // Random traffic under three idling patterns.
      run_random_phase(24, 48);
      run_random_phase(48, 24);
      run_random_phase(0, 0);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && inverses_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
